>>> src/gcrb_pkg.sv
package gcrb_pkg;

  // CORDIC iteration count (12..32)
  localparam int CORDIC_STAGES = 24;

  // datapath widths
  localparam int ROT_W    = 34;
  localparam int VEC_W    = 56;
  localparam int SQ_STEPS = 31;

  // pipeline positions, counted in registers from the input edge
  localparam int POS_DIST = 2 * CORDIC_STAGES + 46;
  localparam int POS_ELEV = 3 * CORDIC_STAGES + 47;
  localparam int LATENCY  = 3 * CORDIC_STAGES + 49;
  localparam int BZ_LEN   = CORDIC_STAGES + 1;
  localparam int BEAR_LEN = CORDIC_STAGES + 37;
  localparam int DIST_LEN = CORDIC_STAGES + 1;

  // arithmetic constants
  localparam logic [29:0] CORDIC_GAIN  = 30'd652032874;
  localparam logic [31:0] PI_Q30       = 32'd3373259426;
  localparam logic [30:0] RECIP45      = 31'd1527099483;  // floor(2^36/45)
  localparam logic [10:0] RECIP45_LO   = 11'd1456;        // floor(2^16/45)
  localparam logic [28:0] DIST_MAX     = 29'h1FFFFFFF;
  localparam logic [22:0] RADIUS_RESET = 23'd6371000;
  localparam logic [60:0] Q60_ONE      = 61'h1000000000000000;

  // atan(2^-k) as binary angle, 2^32 per turn
  localparam logic [31:0] ATAN_BAM [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  typedef struct packed {
    logic signed [31:0] c;
    logic signed [31:0] s;
  } sincos_t;

endpackage

>>> src/great_circle_range_bearing.sv
// Great-circle range and bearing engine.
//
// Input channel (in_valid / in_stall): one request carries start and end
// latitude/longitude (2^-22 degree) and a target altitude (1/16 m).
// Result channel (out_valid / out_stall): per request, the haversine
// downrange distance, line-of-sight elevation angle, initial bearing,
// saturated slant distance and a flag that the elevation is not negative.
// Config channel (cfg_valid / cfg_ready): writes the sphere radius in metres;
// cfg_ready is always high. Write it only while no request is in flight.
//
// Throughput: one request per cycle while out_stall does not hold the
// pipeline. Path: five parallel rotation CORDICs, the two 31-step square
// roots, and two vectoring CORDICs in series.
// Reset clears all valid bits and loads the radius with 6371000 m.
// When out_stall is high with a result waiting, the whole pipeline holds
// and in_stall rises in the same cycle; nothing is dropped or repeated.
module great_circle_range_bearing (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [29:0] in_start_latitude,
  input  logic signed [30:0] in_start_longitude,
  input  logic signed [29:0] in_end_latitude,
  input  logic signed [30:0] in_end_longitude,
  input  logic signed [24:0] in_altitude,
  output logic               out_valid,
  input  logic               out_stall,
  output logic        [28:0] out_downrange_distance,
  output logic signed [29:0] out_elevation_angle,
  output logic signed [30:0] out_initial_bearing,
  output logic        [28:0] out_slant_distance,
  output logic               out_path_valid,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic        [22:0] cfg_earth_radius
);

  localparam int N   = gcrb_pkg::CORDIC_STAGES;
  localparam int LAT = gcrb_pkg::LATENCY;
  localparam int VW  = gcrb_pkg::VEC_W;

  logic           adv;
  logic [LAT-1:0] vld_r;
  logic [22:0]    radius_r;

  // global advance: hold everything while a result waits
  assign adv       = !(vld_r[LAT-1] && out_stall);
  assign in_stall  = !adv;
  assign out_valid = vld_r[LAT-1];
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // radius register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= gcrb_pkg::RADIUS_RESET;
    end else if (cfg_valid) begin
      radius_r <= cfg_earth_radius;
    end
  end

  // altitude travels alongside
  logic signed [24:0] alt_d_r [gcrb_pkg::POS_ELEV];

  always_ff @(posedge clk) begin
    if (adv) begin
      alt_d_r[0] <= in_altitude;
      for (int k = 1; k < gcrb_pkg::POS_ELEV; k++) begin
        alt_d_r[k] <= alt_d_r[k-1];
      end
    end
  end

  // degrees to binary angle
  logic [31:0] p1_bam, l1_bam, p2_bam, l2_bam;

  gcrb_deg2bam u_conv_p1 (.clk, .en(adv), .deg(31'(in_start_latitude)),  .bam(p1_bam));
  gcrb_deg2bam u_conv_l1 (.clk, .en(adv), .deg(in_start_longitude),      .bam(l1_bam));
  gcrb_deg2bam u_conv_p2 (.clk, .en(adv), .deg(31'(in_end_latitude)),    .bam(p2_bam));
  gcrb_deg2bam u_conv_l2 (.clk, .en(adv), .deg(in_end_longitude),        .bam(l2_bam));

  // angle differences
  logic [31:0] p1_r, p2_r, dph_h_r, dla_h_r, dla_r;
  logic [31:0] dphi, dlam;

  assign dphi = p2_bam - p1_bam;
  assign dlam = l2_bam - l1_bam;

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_r    <= p1_bam;
      p2_r    <= p2_bam;
      dph_h_r <= dphi >> 1;
      dla_h_r <= dlam >> 1;
      dla_r   <= dlam;
    end
  end

  // sine and cosine
  gcrb_pkg::sincos_t sc_p1, sc_p2, sc_dph, sc_dlh, sc_dla;

  gcrb_cordic_rot u_rot_p1  (.clk, .en(adv), .ang(p1_r),    .sc(sc_p1));
  gcrb_cordic_rot u_rot_p2  (.clk, .en(adv), .ang(p2_r),    .sc(sc_p2));
  gcrb_cordic_rot u_rot_dph (.clk, .en(adv), .ang(dph_h_r), .sc(sc_dph));
  gcrb_cordic_rot u_rot_dlh (.clk, .en(adv), .ang(dla_h_r), .sc(sc_dlh));
  gcrb_cordic_rot u_rot_dla (.clk, .en(adv), .ang(dla_r),   .sc(sc_dla));

  // products, first level
  logic signed [63:0] sh1sq_r, c1c2_r, c1s2_r, s1c2_r, sdlc2_r;
  logic signed [31:0] sh2_m1_r, cdl_m1_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      sh1sq_r  <= $signed(sc_dph.s) * $signed(sc_dph.s);
      c1c2_r   <= $signed(sc_p1.c) * $signed(sc_p2.c);
      c1s2_r   <= $signed(sc_p1.c) * $signed(sc_p2.s);
      s1c2_r   <= $signed(sc_p1.s) * $signed(sc_p2.c);
      sdlc2_r  <= $signed(sc_dla.s) * $signed(sc_p2.c);
      sh2_m1_r <= sc_dlh.s;
      cdl_m1_r <= sc_dla.c;
    end
  end

  // products, second level
  logic signed [33:0] c1c2_sh, s1c2_sh;
  logic signed [65:0] t_r, w_r;
  logic signed [63:0] sh1sq_m2_r, c1s2_m2_r, sdlc2_m2_r;
  logic signed [31:0] sh2_m2_r;

  assign c1c2_sh = 34'(c1c2_r >>> 30);
  assign s1c2_sh = 34'(s1c2_r >>> 30);

  always_ff @(posedge clk) begin
    if (adv) begin
      t_r        <= c1c2_sh * sh2_m1_r;
      w_r        <= s1c2_sh * cdl_m1_r;
      sh1sq_m2_r <= sh1sq_r;
      c1s2_m2_r  <= c1s2_r;
      sdlc2_m2_r <= sdlc2_r;
      sh2_m2_r   <= sh2_m1_r;
    end
  end

  // third level and bearing terms
  logic signed [35:0]   t_sh;
  logic signed [65:0]   bdiff;
  logic signed [67:0]   u_r;
  logic signed [63:0]   sh1sq_m3_r;
  logic signed [VW-1:0] bx_r, by_r;

  assign t_sh  = 36'(t_r >>> 30);
  assign bdiff = 66'(c1s2_m2_r) - w_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      u_r        <= t_sh * sh2_m2_r;
      sh1sq_m3_r <= sh1sq_m2_r;
      bx_r       <= VW'(bdiff >>> 20);
      by_r       <= VW'(sdlc2_m2_r >>> 20);
    end
  end

  // haversine term, clamped to [0, 1]
  logic signed [67:0] a_sum;
  logic [60:0]        a60_r;
  logic [60:0]        sa_in_r, sb_in_r;

  assign a_sum = 68'(sh1sq_m3_r) + u_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      if (a_sum[67]) begin
        a60_r <= '0;
      end else if (a_sum > 68'sh1000000000000000) begin
        a60_r <= gcrb_pkg::Q60_ONE;
      end else begin
        a60_r <= 61'(a_sum);
      end
      sa_in_r <= a60_r;
      sb_in_r <= gcrb_pkg::Q60_ONE - a60_r;
    end
  end

  // square roots
  logic [30:0] sa, sb;

  gcrb_isqrt u_sqrt_a (.clk, .en(adv), .v(sa_in_r), .root(sa));
  gcrb_isqrt u_sqrt_b (.clk, .en(adv), .v(sb_in_r), .root(sb));

  // half central angle
  logic [31:0]          half_ang;
  logic signed [VW-1:0] half_mag;

  gcrb_cordic_vec u_vec_half (
    .clk, .en(adv),
    .x_in(VW'(sb)), .y_in(VW'(sa)),
    .ang(half_ang), .mag(half_mag)
  );

  // downrange = R * c * pi, rounded
  logic [30:0] half_c;
  logic [54:0] rprod_r;
  logic [54:0] ph_r;
  logic [63:0] pl_r;
  logic [55:0] dsum;
  logic [30:0] dround;
  logic [28:0] dist_r;

  assign half_c = half_ang[31] ? 31'd0 : half_ang[30:0];
  assign dsum   = 56'(ph_r) + 56'(pl_r[63:32]);
  assign dround = 31'((dsum + 56'd16777216) >> 25);

  always_ff @(posedge clk) begin
    if (adv) begin
      rprod_r <= 55'(radius_r) * 55'({half_c, 1'b0});
      ph_r    <= 55'(rprod_r[54:32]) * 55'(gcrb_pkg::PI_Q30);
      pl_r    <= 64'(rprod_r[31:0]) * 64'(gcrb_pkg::PI_Q30);
      dist_r  <= (dround > 31'(gcrb_pkg::DIST_MAX)) ? gcrb_pkg::DIST_MAX : dround[28:0];
    end
  end

  // bearing vectoring, runs in parallel
  logic [31:0]          bear_ang;
  logic signed [VW-1:0] bear_mag;
  logic                 bz_d_r [gcrb_pkg::BZ_LEN];
  logic signed [31:0]   bear_d_r [gcrb_pkg::BEAR_LEN];

  gcrb_cordic_vec u_vec_bear (
    .clk, .en(adv),
    .x_in(bx_r), .y_in(by_r),
    .ang(bear_ang), .mag(bear_mag)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      bz_d_r[0] <= (bx_r == '0) && (by_r == '0);
      for (int k = 1; k < gcrb_pkg::BZ_LEN; k++) begin
        bz_d_r[k] <= bz_d_r[k-1];
      end
      // both terms zero: bearing is zero
      bear_d_r[0] <= bz_d_r[gcrb_pkg::BZ_LEN-1] ? 32'sd0 : $signed(bear_ang);
      for (int k = 1; k < gcrb_pkg::BEAR_LEN; k++) begin
        bear_d_r[k] <= bear_d_r[k-1];
      end
    end
  end

  // elevation vectoring
  logic signed [24:0]   alt_e;
  logic [31:0]          elev_ang;
  logic signed [VW-1:0] elev_mag;
  logic [28:0]          dist_d_r [gcrb_pkg::DIST_LEN];

  assign alt_e = alt_d_r[gcrb_pkg::POS_DIST-1];

  gcrb_cordic_vec u_vec_elev (
    .clk, .en(adv),
    .x_in({3'd0, dist_r, 24'd0}),
    .y_in({{7{alt_e[24]}}, alt_e, 24'd0}),
    .ang(elev_ang), .mag(elev_mag)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      dist_d_r[0] <= dist_r;
      for (int k = 1; k < gcrb_pkg::DIST_LEN; k++) begin
        dist_d_r[k] <= dist_d_r[k-1];
      end
    end
  end

  // slant products and elevation select
  logic signed [24:0] alt_l;
  logic [28:0]        dist_l;
  logic [54:0]        magu;
  logic [52:0]        sph_r;
  logic [61:0]        spl_r;
  logic signed [31:0] elev_bam_r;
  logic signed [31:0] bear_s1_r;
  logic               dz_r;
  logic [24:0]        alt_abs_r;
  logic [28:0]        dist_s1_r;

  assign alt_l  = alt_d_r[gcrb_pkg::POS_ELEV-1];
  assign dist_l = dist_d_r[gcrb_pkg::DIST_LEN-1];
  assign magu   = elev_mag[VW-1] ? 55'd0 : 55'(elev_mag);

  always_ff @(posedge clk) begin
    if (adv) begin
      sph_r     <= 53'(magu[54:32]) * 53'(gcrb_pkg::CORDIC_GAIN);
      spl_r     <= 62'(magu[31:0]) * 62'(gcrb_pkg::CORDIC_GAIN);
      dz_r      <= (dist_l == '0);
      alt_abs_r <= alt_l[24] ? 25'(-alt_l) : 25'(alt_l);
      dist_s1_r <= dist_l;
      bear_s1_r <= bear_d_r[gcrb_pkg::BEAR_LEN-1];
      // straight up or down when there is no downrange
      if (dist_l == '0) begin
        if (alt_l > 25'sd0) begin
          elev_bam_r <= 32'sd1073741824;
        end else if (alt_l < 25'sd0) begin
          elev_bam_r <= -32'sd1073741824;
        end else begin
          elev_bam_r <= 32'sd0;
        end
      end else begin
        elev_bam_r <= $signed(elev_ang);
      end
    end
  end

  // output stage: slant rounding, angle scaling
  logic [53:0]        ssum;
  logic [31:0]        sround;
  logic [31:0]        slant;
  logic signed [39:0] elev_deg, bear_deg;
  logic [28:0]        dist_out_r, slant_out_r;
  logic signed [29:0] elev_out_r;
  logic signed [30:0] bear_out_r;
  logic               pv_out_r;

  assign ssum     = 54'(sph_r) + 54'(spl_r[61:32]);
  assign sround   = 32'((ssum + 54'd2097152) >> 22);
  assign slant    = dz_r ? 32'(alt_abs_r) : sround;
  assign elev_deg = (40'(elev_bam_r) * 40'sd45 + 40'sd64) >>> 7;
  assign bear_deg = (40'(bear_s1_r) * 40'sd45 + 40'sd64) >>> 7;

  always_ff @(posedge clk) begin
    if (adv) begin
      dist_out_r  <= dist_s1_r;
      slant_out_r <= (slant > 32'(gcrb_pkg::DIST_MAX)) ? gcrb_pkg::DIST_MAX : slant[28:0];
      elev_out_r  <= elev_deg[29:0];
      bear_out_r  <= bear_deg[30:0];
      pv_out_r    <= !elev_deg[39];
    end
  end

  assign out_downrange_distance = dist_out_r;
  assign out_elevation_angle    = elev_out_r;
  assign out_initial_bearing    = bear_out_r;
  assign out_slant_distance     = slant_out_r;
  assign out_path_valid         = pv_out_r;

endmodule

>>> src/gcrb_deg2bam.sv
module gcrb_deg2bam (
  input  logic               clk,
  input  logic               en,
  input  logic signed [30:0] deg,
  output logic        [31:0] bam
);

  logic [30:0] mag_nxt;
  logic [30:0] mag_r;
  logic        neg_r;
  logic [61:0] prod_r;

  logic [24:0] q0;
  logic [30:0] r0;
  logic        corr;
  logic [24:0] q1;
  logic [5:0]  r1;
  logic [12:0] t_nxt;
  logic [24:0] q_r;
  logic [12:0] t_r;
  logic [23:0] prod2_r;
  logic        neg2_r;

  logic [7:0]  q2_0;
  logic [12:0] r2;
  logic [6:0]  q2;
  logic [31:0] b;
  logic [31:0] bam_r;

  // stage 1: magnitude and reciprocal product
  always_comb mag_nxt = deg[30] ? 31'(-deg) : 31'(deg);

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r  <= mag_nxt;
      neg_r  <= deg[30];
      prod_r <= {31'd0, mag_nxt} * {31'd0, gcrb_pkg::RECIP45};
    end
  end

  // stage 2: quotient by 45 with one correction, then the remainder term
  always_comb begin
    q0    = prod_r[60:36];
    r0    = mag_r - 31'({6'd0, q0} * 31'd45);
    corr  = (r0 >= 31'd45);
    q1    = q0 + 25'(corr);
    r1    = corr ? 6'(r0 - 31'd45) : 6'(r0);
    t_nxt = {r1, 7'd0} + 13'd22;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r     <= q1;
      t_r     <= t_nxt;
      prod2_r <= {11'd0, t_nxt} * {13'd0, gcrb_pkg::RECIP45_LO};
      neg2_r  <= neg_r;
    end
  end

  // stage 3: small quotient, assemble and apply sign
  always_comb begin
    q2_0 = prod2_r[23:16];
    r2   = t_r - 13'({5'd0, q2_0} * 13'd45);
    q2   = 7'(q2_0) + 7'(r2 >= 13'd45);
    b    = {q_r, 7'd0} + {25'd0, q2};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bam_r <= neg2_r ? -b : b;
    end
  end

  assign bam = bam_r;

endmodule

>>> src/gcrb_cordic_rot.sv
module gcrb_cordic_rot (
  input  logic                clk,
  input  logic                en,
  input  logic [31:0]         ang,
  output gcrb_pkg::sincos_t   sc
);

  localparam int N = gcrb_pkg::CORDIC_STAGES;
  localparam int W = gcrb_pkg::ROT_W;

  logic signed [W-1:0] z_pre;
  logic                flip_pre;

  logic signed [W-1:0] x_r [N+1];
  logic signed [W-1:0] y_r [N+1];
  logic signed [W-1:0] z_r [N+1];
  logic                flip_r [N+1];
  logic signed [W-1:0] x_nxt [N];
  logic signed [W-1:0] y_nxt [N];
  logic signed [W-1:0] z_nxt [N];
  gcrb_pkg::sincos_t   sc_r;

  // fold the angle into +-90 degrees, remember to negate
  always_comb begin
    z_pre    = W'($signed(ang));
    flip_pre = 1'b0;
    if ($signed(ang) > 32'sd1073741824) begin
      z_pre    = W'($signed(ang)) - 34'sd2147483648;
      flip_pre = 1'b1;
    end else if ($signed(ang) < -32'sd1073741824) begin
      z_pre    = W'($signed(ang)) + 34'sd2147483648;
      flip_pre = 1'b1;
    end
  end

  // one micro-rotation per stage
  always_comb begin
    for (int i = 0; i < N; i++) begin
      if (!z_r[i][W-1]) begin
        x_nxt[i] = x_r[i] - (y_r[i] >>> (i % 32));
        y_nxt[i] = y_r[i] + (x_r[i] >>> (i % 32));
        z_nxt[i] = z_r[i] - W'(gcrb_pkg::ATAN_BAM[5'(i)]);
      end else begin
        x_nxt[i] = x_r[i] + (y_r[i] >>> (i % 32));
        y_nxt[i] = y_r[i] - (x_r[i] >>> (i % 32));
        z_nxt[i] = z_r[i] + W'(gcrb_pkg::ATAN_BAM[5'(i)]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= W'(gcrb_pkg::CORDIC_GAIN);
      y_r[0]    <= '0;
      z_r[0]    <= z_pre;
      flip_r[0] <= flip_pre;
      for (int i = 0; i < N; i++) begin
        x_r[i+1]    <= x_nxt[i];
        y_r[i+1]    <= y_nxt[i];
        z_r[i+1]    <= z_nxt[i];
        flip_r[i+1] <= flip_r[i];
      end
      sc_r.c <= 32'(flip_r[N] ? -x_r[N] : x_r[N]);
      sc_r.s <= 32'(flip_r[N] ? -y_r[N] : y_r[N]);
    end
  end

  assign sc = sc_r;

endmodule

>>> src/gcrb_cordic_vec.sv
module gcrb_cordic_vec (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [gcrb_pkg::VEC_W-1:0] x_in,
  input  logic signed [gcrb_pkg::VEC_W-1:0] y_in,
  output logic        [31:0]                ang,
  output logic signed [gcrb_pkg::VEC_W-1:0] mag
);

  localparam int N = gcrb_pkg::CORDIC_STAGES;
  localparam int W = gcrb_pkg::VEC_W;

  logic signed [W-1:0] x_r [N+1];
  logic signed [W-1:0] y_r [N+1];
  logic        [31:0]  z_r [N+1];
  logic signed [W-1:0] x_nxt [N];
  logic signed [W-1:0] y_nxt [N];
  logic        [31:0]  z_nxt [N];

  // drive y toward zero, one step per stage
  always_comb begin
    for (int i = 0; i < N; i++) begin
      if (!y_r[i][W-1]) begin
        x_nxt[i] = x_r[i] + (y_r[i] >>> (i % 32));
        y_nxt[i] = y_r[i] - (x_r[i] >>> (i % 32));
        z_nxt[i] = z_r[i] + gcrb_pkg::ATAN_BAM[5'(i)];
      end else begin
        x_nxt[i] = x_r[i] - (y_r[i] >>> (i % 32));
        y_nxt[i] = y_r[i] + (x_r[i] >>> (i % 32));
        z_nxt[i] = z_r[i] - gcrb_pkg::ATAN_BAM[5'(i)];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // left half plane: rotate by half a turn first
      if (x_in[W-1]) begin
        x_r[0] <= -x_in;
        y_r[0] <= -y_in;
        z_r[0] <= 32'h80000000;
      end else begin
        x_r[0] <= x_in;
        y_r[0] <= y_in;
        z_r[0] <= '0;
      end
      for (int i = 0; i < N; i++) begin
        x_r[i+1] <= x_nxt[i];
        y_r[i+1] <= y_nxt[i];
        z_r[i+1] <= z_nxt[i];
      end
    end
  end

  assign ang = z_r[N];
  assign mag = x_r[N];

endmodule

>>> src/gcrb_isqrt.sv
module gcrb_isqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [60:0] v,
  output logic [30:0] root
);

  localparam int S = gcrb_pkg::SQ_STEPS;

  logic [60:0] rem_s  [S+1];
  logic [61:0] root_s [S+1];
  logic [61:0] trial  [S];
  logic [60:0] rem_nxt  [S];
  logic [61:0] root_nxt [S];
  logic [60:0] rem_r  [S];
  logic [61:0] root_r [S];

  // one result bit per stage, restoring form
  always_comb begin
    rem_s[0]  = v;
    root_s[0] = '0;
    for (int j = 0; j < S; j++) begin
      rem_s[j+1]  = rem_r[j];
      root_s[j+1] = root_r[j];
    end
    for (int j = 0; j < S; j++) begin
      trial[j] = root_s[j] + (62'd1 << (2 * (S - 1 - j)));
      if ({1'b0, rem_s[j]} >= trial[j]) begin
        rem_nxt[j]  = 61'({1'b0, rem_s[j]} - trial[j]);
        root_nxt[j] = (root_s[j] >> 1) + (62'd1 << (2 * (S - 1 - j)));
      end else begin
        rem_nxt[j]  = rem_s[j];
        root_nxt[j] = root_s[j] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < S; j++) begin
        rem_r[j]  <= rem_nxt[j];
        root_r[j] <= root_nxt[j];
      end
    end
  end

  assign root = root_r[S-1][30:0];

endmodule

>>> dv/great_circle_range_bearing_tb.sv
`timescale 1ns / 100ps

module great_circle_range_bearing_tb;

  // one result of the block, as the ports present it
  typedef struct {
    logic        [28:0] drange;
    logic signed [29:0] elev;
    logic signed [30:0] bear;
    logic        [28:0] slant;
    logic               pv;
  } fix_t;

  // predicts range/bearing fixes and checks them in order
  class range_bearing_ledger;
    fix_t pending_fixes[$];
    longint unsigned radius_m;
    int mismatches;

    function new();
      radius_m = gcrb_pkg::RADIUS_RESET;
      mismatches = 0;
    endfunction

    function longint bam_s(bit [31:0] u);
      return longint'($signed(u));
    endfunction

    function bit [31:0] to_bam(longint v);
      longint num;
      longint b;
      num = v * 128;
      b = (num >= 0) ? (num + 22) / 45 : -((-num + 22) / 45);
      return b[31:0];
    endfunction

    function longint to_deg(longint b);
      return (b * 45 + 64) >>> 7;
    endfunction

    // rounded x * k / 2^s
    function longint unsigned scale_round(longint unsigned x, longint unsigned k, int s);
      longint unsigned hi;
      longint unsigned lo;
      longint unsigned t;
      hi = x >> 32;
      lo = x & 64'hFFFF_FFFF;
      t = hi * k + ((lo * k) >> 32);
      return (t + (64'd1 << (s - 33))) >> (s - 32);
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    // rotation mode: Q30 cosine and sine of a binary angle
    function void sin_cos(bit [31:0] ang, output longint c, output longint s);
      longint z;
      longint x;
      longint y;
      longint xs;
      longint ys;
      bit flip;
      int k;
      z = bam_s(ang);
      x = longint'(gcrb_pkg::CORDIC_GAIN);
      y = 0;
      flip = 0;
      if (z > (64'sd1 << 30)) begin
        z = z - (64'sd1 << 31);
        flip = 1;
      end else if (z < -(64'sd1 << 30)) begin
        z = z + (64'sd1 << 31);
        flip = 1;
      end
      for (int i = 0; i < gcrb_pkg::CORDIC_STAGES; i++) begin
        k = i % 32;
        xs = x >>> k;
        ys = y >>> k;
        if (z >= 0) begin
          x = x - ys;
          y = y + xs;
          z = z - longint'(gcrb_pkg::ATAN_BAM[k]);
        end else begin
          x = x + ys;
          y = y - xs;
          z = z + longint'(gcrb_pkg::ATAN_BAM[k]);
        end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    // vectoring mode: atan2(y, x) as binary angle, scaled magnitude
    function bit [31:0] arc_tan(longint x, longint y, output longint mag);
      bit [31:0] z;
      longint xs;
      longint ys;
      int k;
      z = 0;
      if (x < 0) begin
        x = -x;
        y = -y;
        z = 32'h8000_0000;
      end
      for (int i = 0; i < gcrb_pkg::CORDIC_STAGES; i++) begin
        k = i % 32;
        xs = x >>> k;
        ys = y >>> k;
        if (y >= 0) begin
          x = x + ys;
          y = y - xs;
          z = z + gcrb_pkg::ATAN_BAM[k];
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - gcrb_pkg::ATAN_BAM[k];
        end
      end
      mag = x;
      return z;
    endfunction

    function void note_request(logic signed [29:0] lat1, logic signed [30:0] lon1,
                               logic signed [29:0] lat2, logic signed [30:0] lon2,
                               logic signed [24:0] alt_in);
      bit [31:0] p1, l1, p2, l2, dphi, dlam;
      longint c1, s1, c2, s2, ch, sh1, sh2, cdl, sdl, mag;
      longint a60, half, bx, by, elev_b, bear_b, elev_d, bear_d, alt;
      longint unsigned sa, sb, drange, slant;
      fix_t f;
      p1 = to_bam(longint'(lat1));
      l1 = to_bam(longint'(lon1));
      p2 = to_bam(longint'(lat2));
      l2 = to_bam(longint'(lon2));
      alt = longint'(alt_in);
      dphi = p2 - p1;
      dlam = l2 - l1;
      sin_cos(p1, c1, s1);
      sin_cos(p2, c2, s2);
      sin_cos(dphi >> 1, ch, sh1);
      sin_cos(dlam >> 1, ch, sh2);
      sin_cos(dlam, cdl, sdl);

      // haversine term, Q60, clamped to [0, 1]
      a60 = sh1 * sh1 + ((((c1 * c2) >>> 30) * sh2) >>> 30) * sh2;
      if (a60 < 0) a60 = 0;
      if (a60 > (64'sd1 << 60)) a60 = 64'sd1 << 60;
      sa = int_sqrt(a60);
      sb = int_sqrt((64'd1 << 60) - a60);
      half = bam_s(arc_tan(longint'(sb), longint'(sa), mag));
      if (half < 0) half = 0;
      drange = scale_round(radius_m * longint'(2 * half), gcrb_pkg::PI_Q30, 57);
      if (drange > gcrb_pkg::DIST_MAX) drange = gcrb_pkg::DIST_MAX;

      // initial bearing; zero when both terms vanish
      by = (sdl * c2) >>> 20;
      bx = (c1 * s2 - ((s1 * c2) >>> 30) * cdl) >>> 20;
      if (bx == 0 && by == 0) bear_b = 0;
      else bear_b = bam_s(arc_tan(bx, by, mag));

      // elevation and slant; straight up or down at zero range
      if (drange == 0) begin
        elev_b = (alt > 0) ? (64'sd1 << 30) : ((alt < 0) ? -(64'sd1 << 30) : 0);
        slant = (alt < 0) ? -alt : alt;
      end else begin
        elev_b = bam_s(arc_tan(longint'(drange) <<< 24, alt * (64'sd1 << 24), mag));
        slant = scale_round((mag < 0) ? 0 : mag, gcrb_pkg::CORDIC_GAIN, 54);
      end
      if (slant > gcrb_pkg::DIST_MAX) slant = gcrb_pkg::DIST_MAX;

      elev_d = to_deg(elev_b);
      bear_d = to_deg(bear_b);
      f.drange = drange[28:0];
      f.elev = elev_d[29:0];
      f.bear = bear_d[30:0];
      f.slant = slant[28:0];
      f.pv = (elev_d >= 0);
      pending_fixes = {pending_fixes, f};
    endfunction

    function void check_result(fix_t got);
      fix_t e;
      if (pending_fixes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: dist=%0d elev=%0d bear=%0d slant=%0d pv=%0d",
                   got.drange, got.elev, got.bear, got.slant, got.pv);
        return;
      end
      e = pending_fixes.pop_front();
      if (got.drange !== e.drange || got.elev !== e.elev || got.bear !== e.bear ||
          got.slant !== e.slant || got.pv !== e.pv) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch exp: dist=%0d elev=%0d bear=%0d slant=%0d pv=%0d",
                   e.drange, e.elev, e.bear, e.slant, e.pv);
          $display("         got: dist=%0d elev=%0d bear=%0d slant=%0d pv=%0d",
                   got.drange, got.elev, got.bear, got.slant, got.pv);
        end
      end
    endfunction
  endclass

  localparam int IDLE_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam logic signed [29:0] LAT_MAX = 30'sd377487360;
  localparam logic signed [30:0] LON_MAX = 31'sd754974720;

  logic               clk = 0;
  logic               rst_n = 0;
  logic               in_valid = 0;
  logic               in_stall;
  logic signed [29:0] in_start_latitude = '0;
  logic signed [30:0] in_start_longitude = '0;
  logic signed [29:0] in_end_latitude = '0;
  logic signed [30:0] in_end_longitude = '0;
  logic signed [24:0] in_altitude = '0;
  logic               out_valid;
  logic               out_stall = 1;
  logic        [28:0] out_downrange_distance;
  logic signed [29:0] out_elevation_angle;
  logic signed [30:0] out_initial_bearing;
  logic        [28:0] out_slant_distance;
  logic               out_path_valid;
  logic               cfg_valid = 0;
  logic               cfg_ready;
  logic        [22:0] cfg_earth_radius = '0;

  range_bearing_ledger ledger = new();
  int phase = 0;
  int results_seen = 0;
  int idle_cycles = 0;

  great_circle_range_bearing dut (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  // watchdog: cycles with no handshake on any channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("great_circle_range_bearing_tb: errors");
      $finish;
    end
  end

  // result side: random stalls, one long hold to back the pipe up
  initial begin
    int gap;
    fix_t got;
    @(posedge rst_n);
    forever begin
      if (results_seen == 150) gap = HOLD_CYCLES;
      else if (phase == 2) gap = 0;
      else gap = $urandom_range(0, 16);
      if (gap > 0) begin
        out_stall <= 1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 0;
      do @(posedge clk); while (!out_valid);
      got.drange = out_downrange_distance;
      got.elev = out_elevation_angle;
      got.bear = out_initial_bearing;
      got.slant = out_slant_distance;
      got.pv = out_path_valid;
      ledger.check_result(got);
      results_seen++;
    end
  end

  task automatic send_req(logic signed [29:0] lat1, logic signed [30:0] lon1,
                          logic signed [29:0] lat2, logic signed [30:0] lon2,
                          logic signed [24:0] alt);
    int gap;
    gap = (phase == 1) ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_start_latitude <= lat1;
    in_start_longitude <= lon1;
    in_end_latitude <= lat2;
    in_end_longitude <= lon2;
    in_altitude <= alt;
    do @(posedge clk); while (in_stall);
    ledger.note_request(lat1, lon1, lat2, lon2, alt);
  endtask

  // wait for the pipe to drain, then load a new radius
  task automatic set_radius(logic [22:0] r);
    in_valid <= 0;
    wait (ledger.pending_fixes.size() == 0);
    @(posedge clk);
    cfg_valid <= 1;
    cfg_earth_radius <= r;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    ledger.radius_m = r;
  endtask

  function automatic logic signed [29:0] pick_lat();
    case ($urandom_range(0, 9))
      0: return 30'($urandom);
      1: return $urandom_range(0, 1) ? LAT_MAX : -LAT_MAX;
      default: return 30'($urandom_range(0, 2 * 377487360) - 377487360);
    endcase
  endfunction

  function automatic logic signed [30:0] pick_lon();
    case ($urandom_range(0, 9))
      0: return 31'($urandom);
      1: return $urandom_range(0, 1) ? LON_MAX : -LON_MAX;
      default: return 31'($urandom_range(0, 2 * 754974720) - 754974720);
    endcase
  endfunction

  function automatic logic signed [24:0] pick_alt();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 25'($urandom_range(0, 2000) - 1000);
      default: return 25'($urandom);
    endcase
  endfunction

  // mostly nearby pairs, where elevation and slant are interesting
  task automatic send_random();
    logic signed [29:0] lat1;
    logic signed [30:0] lon1;
    lat1 = pick_lat();
    lon1 = pick_lon();
    if ($urandom_range(0, 9) < 6)
      send_req(lat1, lon1, lat1 + 30'($urandom_range(0, 2000000) - 1000000),
               lon1 + 31'($urandom_range(0, 2000000) - 1000000), pick_alt());
    else
      send_req(lat1, lon1, pick_lat(), pick_lon(), pick_alt());
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: coincident points, poles, due south, field extremes
    send_req(0, 0, 0, 0, 0);
    send_req(1000, 2000, 1000, 2000, 4096);
    send_req(1000, 2000, 1000, 2000, -4096);
    send_req(LAT_MAX, 0, -LAT_MAX, 0, 100);
    send_req(LAT_MAX, 0, LAT_MAX, 300000000, 0);
    send_req(-LAT_MAX, 123, -LAT_MAX, -LON_MAX, 7);
    send_req(1000000, 5, -1000000, 5, 16);
    send_req(0, -LON_MAX, 0, LON_MAX, 25'sh0FFFFFF);
    send_req(0, 0, 0, LON_MAX, 0);
    send_req(-LAT_MAX, -LON_MAX, -LAT_MAX, -LON_MAX, -25'sh1000000);
    send_req(LAT_MAX, LON_MAX, LAT_MAX, LON_MAX, 25'sh0FFFFFF);
    send_req(-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX, -25'sh1000000);
    send_req(30'sh1FFFFFFF, -31'sh40000000, -30'sh20000000, 31'sh3FFFFFFF, -1);
    send_req(-30'sh20000000, 31'sh3FFFFFFF, 30'sh1FFFFFFF, -31'sh40000000, 1);
    send_req(0, 0, 1, 0, 25'sh0FFFFFF);
    send_req(0, 0, 0, 1, -25'sh1000000);
    send_req(100, 200, 120, 210, -5000);
    send_req(4194304, 8388608, 4194400, 8388700, 0);
    send_req(-200000000, 600000000, 200000000, -600000000, 12345);

    // random phases, each with its own radius
    for (int p = 0; p < 4; p++) begin
      phase = p;
      case (p)
        1: set_radius(23'd6000000);
        2: set_radius(23'd7000000);
        3: set_radius(23'($urandom_range(6000000, 7000000)));
        default: ;
      endcase
      repeat (112) send_random();
    end
    in_valid <= 0;

    wait (ledger.pending_fixes.size() == 0);
    repeat (gcrb_pkg::LATENCY + 20) @(posedge clk);
    if (ledger.mismatches == 0)
      $display("great_circle_range_bearing_tb: clean");
    else
      $display("great_circle_range_bearing_tb: errors");
    $finish;
  end

endmodule
